// File: sv/ccpo_pkg.sv
package ccpo_pkg;

    // Lattice and field sizes.
    localparam int MAX_DIM  = 16;
    localparam int MIN_DIM  = 3;
    localparam int DIM_W    = 5;
    localparam int COORD_W  = $clog2(MAX_DIM);
    localparam int IDX_W    = 8;
    localparam int QUBIT_W  = 9;
    localparam int DELTA_W  = 7;
    localparam int STEP_CAP = 16;
    localparam int STEP_W   = $clog2(STEP_CAP);
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd1;

    // Vertex colours.
    localparam logic [1:0] COLOR_0 = 2'd0;
    localparam logic [1:0] COLOR_1 = 2'd1;
    localparam logic [1:0] COLOR_2 = 2'd2;

    // Effective lattice size after clamping.
    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } dims_t;

    // One walk job handed from the front to the walker.
    typedef struct packed {
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
        logic signed [DELTA_W-1:0] dr;
        logic signed [DELTA_W-1:0] dc;
    } job_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    // Clamp a configured size into the supported range.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v < DIM_W'(MIN_DIM))
        begin
            res = DIM_W'(MIN_DIM);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            res = DIM_W'(MAX_DIM);
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

    // Remainder by three of a value below 32, through a reciprocal multiply.
    function automatic logic [1:0] mod3(input logic [COORD_W:0] s);
        logic [COORD_W+4:0] prod;
        logic [COORD_W-1:0] quo;
        logic [COORD_W+1:0] rem;
        prod = (COORD_W+5)'(s) * (COORD_W+5)'(11);
        quo  = prod[COORD_W+4:5];
        rem  = (COORD_W+2)'(s) - (COORD_W+2)'(quo) * (COORD_W+2)'(3);
        return rem[1:0];
    endfunction

endpackage

// File: sv/ccpo_if.sv
// Vertex request channel.
interface ccpo_vertex_if import ccpo_pkg::*;;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] vertex_index;

    modport source (output valid, output vertex_index, input ready);
    modport sink   (input valid, input vertex_index, output ready);
endinterface

// Qubit result channel.
interface ccpo_qubit_if import ccpo_pkg::*;;
    logic               valid;
    logic               ready;
    logic [QUBIT_W-1:0] qubit_index;
    logic               last;

    modport source (output valid, output qubit_index, output last, input ready);
    modport sink   (input valid, input qubit_index, input last, output ready);
endinterface

// Configuration write channel.
interface ccpo_cfg_if import ccpo_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/ccpo_front.sv
module ccpo_front import ccpo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dims_t                dims,
    ccpo_vertex_if.sink          vertex,
    output logic                 job_valid,
    input  logic                 job_ready,
    output job_t                 job
);

    front_state_t       state_reg, state_next;
    logic [IDX_W-1:0]   rem_reg;
    logic [COORD_W-1:0] row_reg;
    job_t               job_reg;

    logic [2*DIM_W-1:0] area;
    logic               in_range;
    logic               accept;
    logic               div_more;
    logic [COORD_W-1:0] col;
    logic [COORD_W:0]   sum;
    logic [1:0]         color;
    job_t               job_calc;
    logic               root;

    // Range check of the incoming index against the lattice area.
    assign area     = (2*DIM_W)'(dims.rows) * (2*DIM_W)'(dims.cols);
    assign in_range = (2*DIM_W)'(vertex.vertex_index) < area;
    assign accept   = vertex.valid && vertex.ready;

    // One row is peeled off the index per cycle while the remainder is a full row.
    assign div_more = rem_reg >= IDX_W'(dims.cols);

    // Colour and offset to the root corner of the same colour.
    always_comb
    begin
        col          = rem_reg[COORD_W-1:0];
        sum          = {1'b0, row_reg} + {1'b0, col};
        color        = mod3(sum);
        job_calc.row = row_reg;
        job_calc.col = col;
        job_calc.dr  = $signed({{(DELTA_W-COORD_W){1'b0}}, row_reg});
        job_calc.dc  = $signed({{(DELTA_W-COORD_W){1'b0}}, col});
        case (color)
            COLOR_0:
            begin
                job_calc.dr = job_calc.dr;
            end
            COLOR_1:
            begin
                job_calc.dc = job_calc.dc - DELTA_W'(1);
            end
            COLOR_2:
            begin
                job_calc.dr = job_calc.dr - DELTA_W'(1);
                job_calc.dc = job_calc.dc - DELTA_W'(1);
            end
            default:
            begin
                job_calc.dr = job_calc.dr;
            end
        endcase
        root = (job_calc.dr == '0) && (job_calc.dc == '0);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE:
            begin
                if (accept && in_range)
                begin
                    state_next = FR_DIV;
                end
            end
            FR_DIV:
            begin
                if (!div_more)
                begin
                    state_next = root ? FR_IDLE : FR_PUSH;
                end
            end
            FR_PUSH:
            begin
                if (job_ready)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        vertex.ready = 1'b0;
        job_valid    = 1'b0;
        case (state_reg)
            FR_IDLE:
            begin
                vertex.ready = 1'b1;
            end
            FR_DIV:
            begin
                job_valid = 1'b0;
            end
            FR_PUSH:
            begin
                job_valid = 1'b1;
            end
            default:
            begin
                job_valid = 1'b0;
            end
        endcase
    end

    assign job = job_reg;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Division datapath and job capture.
    always_ff @(posedge clk)
    begin
        if (state_reg == FR_IDLE)
        begin
            rem_reg <= vertex.vertex_index;
            row_reg <= '0;
        end
        else if (state_reg == FR_DIV)
        begin
            if (div_more)
            begin
                rem_reg <= rem_reg - IDX_W'(dims.cols);
                row_reg <= row_reg + COORD_W'(1);
            end
            else
            begin
                job_reg <= job_calc;
            end
        end
    end

endmodule

// File: sv/ccpo_queue.sv
module ccpo_queue import ccpo_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    // Two-entry job queue between the front and the walker.
    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/ccpo_walker.sv
module ccpo_walker import ccpo_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  dims_t         dims,
    input  logic          job_valid,
    output logic          job_ready,
    input  job_t          job,
    ccpo_qubit_if.source  qubit
);

    logic                      busy_reg;
    logic                      phase_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [COORD_W-1:0]        r_reg;
    logic [COORD_W-1:0]        c_reg;
    logic signed [DELTA_W-1:0] dr_reg;
    logic signed [DELTA_W-1:0] dc_reg;
    logic                      out_valid_reg;
    logic [QUBIT_W-1:0]        out_qubit_reg;
    logic                      out_last_reg;

    logic [DIM_W-1:0]          r_ext;
    logic [DIM_W-1:0]          c_ext;
    logic [DIM_W-1:0]          tmp_up2;
    logic [DIM_W-1:0]          tmp_left2;
    logic [COORD_W-1:0]        up1;
    logic [COORD_W-1:0]        up2;
    logic [COORD_W-1:0]        down1;
    logic [COORD_W-1:0]        left1;
    logic [COORD_W-1:0]        left2;
    logic [COORD_W-1:0]        right1;
    logic [COORD_W-1:0]        sel_row;
    logic [COORD_W-1:0]        sel_col;
    logic                      sel_side;
    logic [COORD_W-1:0]        r_n;
    logic [COORD_W-1:0]        c_n;
    logic signed [DELTA_W-1:0] dr_n;
    logic signed [DELTA_W-1:0] dc_n;
    logic [QUBIT_W-1:0]        lin;
    logic [QUBIT_W-1:0]        qubit_calc;
    logic                      step_last;
    logic                      advance;

    // Wrapped neighbour coordinates on the torus.
    always_comb
    begin
        r_ext     = {1'b0, r_reg};
        c_ext     = {1'b0, c_reg};
        tmp_up2   = r_ext + dims.rows - DIM_W'(2);
        tmp_left2 = c_ext + dims.cols - DIM_W'(2);
        up1       = (r_reg == '0) ? COORD_W'(dims.rows - DIM_W'(1)) : r_reg - COORD_W'(1);
        left1     = (c_reg == '0) ? COORD_W'(dims.cols - DIM_W'(1)) : c_reg - COORD_W'(1);
        up2       = (r_ext >= DIM_W'(2)) ? COORD_W'(r_ext - DIM_W'(2)) : tmp_up2[COORD_W-1:0];
        left2     = (c_ext >= DIM_W'(2)) ? COORD_W'(c_ext - DIM_W'(2))
                                         : tmp_left2[COORD_W-1:0];
        down1     = (r_ext == dims.rows - DIM_W'(1)) ? '0 : r_reg + COORD_W'(1);
        right1    = (c_ext == dims.cols - DIM_W'(1)) ? '0 : c_reg + COORD_W'(1);
    end

    // Step rule selection: which two qubits and where the walk moves next.
    always_comb
    begin
        if ((dr_reg > dc_reg) && (dc_reg > 0))
        begin
            // Two rows up, one column left.
            sel_row  = phase_reg ? up2 : up1;
            sel_col  = left1;
            sel_side = !phase_reg;
            r_n      = up2;
            c_n      = left1;
            dr_n     = dr_reg - DELTA_W'(2);
            dc_n     = dc_reg - DELTA_W'(1);
        end
        else if ((dc_reg > dr_reg) && (dr_reg > 0))
        begin
            // One row up, two columns left.
            sel_row  = up1;
            sel_col  = phase_reg ? left2 : left1;
            sel_side = phase_reg;
            r_n      = up1;
            c_n      = left2;
            dr_n     = dr_reg - DELTA_W'(1);
            dc_n     = dc_reg - DELTA_W'(2);
        end
        else if (dr_reg <= 0)
        begin
            // One row down, one column left.
            sel_row  = r_reg;
            sel_col  = left1;
            sel_side = !phase_reg;
            r_n      = down1;
            c_n      = left1;
            dr_n     = dr_reg + DELTA_W'(1);
            dc_n     = dc_reg - DELTA_W'(1);
        end
        else
        begin
            // One row up, one column right.
            sel_row  = up1;
            sel_col  = c_reg;
            sel_side = phase_reg;
            r_n      = up1;
            c_n      = right1;
            dr_n     = dr_reg - DELTA_W'(1);
            dc_n     = dc_reg + DELTA_W'(1);
        end
    end

    // Qubit index 2*(row*cols + col) + side.
    always_comb
    begin
        lin        = QUBIT_W'(sel_row) * QUBIT_W'(dims.cols) + QUBIT_W'(sel_col);
        qubit_calc = {lin[QUBIT_W-2:0], sel_side};
    end

    // The walk ends at the corner or after the step limit.
    assign step_last = phase_reg &&
                       (((dr_n == '0) && (dc_n == '0)) || (step_reg == STEP_W'(STEP_CAP - 1)));
    assign advance   = busy_reg && (!out_valid_reg || qubit.ready);
    assign job_ready = !busy_reg;

    assign qubit.valid       = out_valid_reg;
    assign qubit.qubit_index = out_qubit_reg;
    assign qubit.last        = out_last_reg;

    // Walker control and output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!busy_reg)
            begin
                if (job_valid)
                begin
                    busy_reg  <= 1'b1;
                    phase_reg <= 1'b0;
                    step_reg  <= '0;
                end
            end
            else if (advance)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg)
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_last)
                    begin
                        busy_reg <= 1'b0;
                    end
                end
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (qubit.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Walker position and output payload.
    always_ff @(posedge clk)
    begin
        if (!busy_reg && job_valid)
        begin
            r_reg  <= job.row;
            c_reg  <= job.col;
            dr_reg <= job.dr;
            dc_reg <= job.dc;
        end
        else if (advance && phase_reg)
        begin
            r_reg  <= r_n;
            c_reg  <= c_n;
            dr_reg <= dr_n;
            dc_reg <= dc_n;
        end
        if (advance)
        begin
            out_qubit_reg <= qubit_calc;
            out_last_reg  <= step_last;
        end
    end

endmodule

// File: sv/color_code_path_to_origin.sv
// Channel   Role    Payload
// cfg       sink    index (row_count = 0, col_count = 1), data
// vertex    sink    vertex_index
// qubit     source  qubit_index, last
//
// The front splits the index into row and column by one subtraction of the
// column count per cycle and takes no new request until its job is queued or
// dropped; a request outside the lattice is dropped without leaving idle.
// The walker emits one qubit index per cycle while the qubit channel takes
// them, two per step, once it has loaded a job from the queue.
// Requests outside the lattice and root vertices are dropped in the front.
// A two-entry queue lets the front divide the next request while the walker
// is stalled by the qubit channel. Reset sets both sizes to 12.
module color_code_path_to_origin import ccpo_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ccpo_cfg_if.sink      cfg,
    ccpo_vertex_if.sink   vertex,
    ccpo_qubit_if.source  qubit
);

    logic [DIM_W-1:0] row_count_reg;
    logic [DIM_W-1:0] col_count_reg;
    dims_t            dims;
    logic             fq_valid;
    logic             fq_ready;
    job_t             fq_data;
    logic             qw_valid;
    logic             qw_ready;
    job_t             qw_data;

    // Configuration registers, always ready.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= DIM_W'(12);
            col_count_reg <= DIM_W'(12);
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_ROW_COUNT)
            begin
                row_count_reg <= cfg.data;
            end
            else if (cfg.index == CFG_COL_COUNT)
            begin
                col_count_reg <= cfg.data;
            end
        end
    end

    // Effective lattice size.
    assign dims.rows = clamp_dim(row_count_reg);
    assign dims.cols = clamp_dim(col_count_reg);

    ccpo_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dims      (dims),
        .vertex    (vertex),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_data)
    );

    ccpo_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qw_valid),
        .pop_ready  (qw_ready),
        .pop_data   (qw_data)
    );

    ccpo_walker u_walker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dims      (dims),
        .job_valid (qw_valid),
        .job_ready (qw_ready),
        .job       (qw_data),
        .qubit     (qubit)
    );

endmodule
